>>> rtl/avvr_pkg.sv
// Shared constants, widths and tables for the axis-angle vector rotation unit.
`timescale 1ns / 1ps
package avvr_pkg;

  localparam int VEC_WIDTH_DEF   = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  localparam int CORDIC_ITERS = 16;
  localparam int SINCOS_LAT   = CORDIC_ITERS + 2;
  localparam int MATH_LAT     = 5;

  localparam int AXIS_W  = 16;
  localparam int TRIG_W  = 16;
  localparam int CX_W    = 34;
  localparam int CZ_W    = 33;
  localparam int PHASE_W = 32;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [AXIS_W-1:0] ONE_Q14 = 16'sd16384;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [31:0] ATAN_TABLE [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

endpackage

>>> rtl/axis_angle_vector_rotation_unit.sv
// Top level: Rodrigues rotation of a streamed 3-vector about a Q1.14 axis.
`timescale 1ns / 1ps
// Pipeline: an accepted input word passes the CORDIC sine/cosine pipeline, then
//   matrix build, products and rounding, before it leaves as its result word.
// Throughput: one word per cycle; the whole pipeline advances whenever the
//   output register is empty or its word is taken.
// Reset: rst_n (synchronous, active low) clears all valid bits; data holds.
module axis_angle_vector_rotation_unit #(
  parameter int VEC_WIDTH   = avvr_pkg::VEC_WIDTH_DEF,
  parameter int ANGLE_WIDTH = avvr_pkg::ANGLE_WIDTH_DEF,
  localparam int IN_W   = 3*VEC_WIDTH + 3*avvr_pkg::AXIS_W + ANGLE_WIDTH,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = 3*(VEC_WIDTH + 1),
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle, zero pad
  input  logic [IN_TW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // rot_x, rot_y, rot_z, zero pad
  output logic [OUT_TW-1:0] out_tdata,
  // clipped
  output logic              out_tuser
);
  import avvr_pkg::*;

  localparam int LAT   = SINCOS_LAT + MATH_LAT;
  localparam int VW    = VEC_WIDTH;
  localparam int AO    = 3*VW;
  localparam int UU_W  = 30;
  localparam int T_W   = 17;
  localparam int P_W   = UU_W + T_W;
  localparam int CS_W  = 30;
  localparam int ACC_W = 48;
  localparam int M_W   = 32;
  localparam int MV_W  = M_W + VW;
  localparam int SUM_W = MV_W + 2;
  localparam int R_W   = SUM_W - 28;
  localparam logic signed [R_W-1:0] HI_LIM = {{(R_W-VW){1'b0}}, {VW{1'b1}}};
  localparam logic signed [R_W-1:0] LO_LIM = {{(R_W-VW){1'b1}}, {VW{1'b0}}};

  logic adv;
  logic vld_r [0:LAT-1];

  logic signed [VW-1:0]     v_r [0:SINCOS_LAT-1][3];
  logic signed [AXIS_W-1:0] u_r [0:SINCOS_LAT-1][3];
  logic signed [AXIS_W-1:0] u_in [3];
  logic signed [AXIS_W-1:0] raw_u [3];
  logic signed [TRIG_W-1:0] cos_q14, sin_q14;

  // stage M1
  logic signed [UU_W-1:0]  uu_r [6];
  logic signed [CS_W-1:0]  cs_r [3];
  logic signed [T_W-1:0]   t_r;
  logic signed [TRIG_W-1:0] c1_r;
  logic signed [VW-1:0]    v1_r [3];
  // stage M2
  logic signed [P_W-1:0]   p_r [6];
  logic signed [CS_W-1:0]  cs2_r [3];
  logic signed [TRIG_W-1:0] c2_r;
  logic signed [VW-1:0]    v2_r [3];
  // stage M3
  logic signed [M_W-1:0]   m_nxt [3][3];
  logic signed [M_W-1:0]   m_r [3][3];
  logic signed [VW-1:0]    v3_r [3];
  // stage M4
  logic signed [MV_W-1:0]  mv_r [3][3];
  // stage M5
  logic signed [VW:0]      rot_nxt [3];
  logic                    clip_nxt;
  logic signed [VW:0]      rot_r [3];
  logic                    clip_r;

  assign adv       = !vld_r[LAT-1] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // saturate the axis to +/-1.0 on the way in
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      raw_u[k] = $signed(in_tdata[AO + k*AXIS_W +: AXIS_W]);
      if (raw_u[k] > ONE_Q14)       u_in[k] = ONE_Q14;
      else if (raw_u[k] < -ONE_Q14) u_in[k] = -ONE_Q14;
      else                          u_in[k] = raw_u[k];
    end
  end

  // delay vector and axis alongside the CORDIC
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        v_r[0][k] <= $signed(in_tdata[k*VW +: VW]);
        u_r[0][k] <= u_in[k];
      end
      for (int d = 1; d < SINCOS_LAT; d++) begin
        v_r[d] <= v_r[d-1];
        u_r[d] <= u_r[d-1];
      end
    end
  end

  avvr_sincos #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_sincos (
    .clk     (clk),
    .en      (adv),
    .angle   (in_tdata[AO + 3*AXIS_W +: ANGLE_WIDTH]),
    .cos_q14 (cos_q14),
    .sin_q14 (sin_q14)
  );

  // M1: axis outer products, axis times sine, t = 1 - c
  always_ff @(posedge clk) begin
    if (adv) begin
      uu_r[0] <= UU_W'(u_r[SINCOS_LAT-1][0]) * UU_W'(u_r[SINCOS_LAT-1][0]);
      uu_r[1] <= UU_W'(u_r[SINCOS_LAT-1][0]) * UU_W'(u_r[SINCOS_LAT-1][1]);
      uu_r[2] <= UU_W'(u_r[SINCOS_LAT-1][0]) * UU_W'(u_r[SINCOS_LAT-1][2]);
      uu_r[3] <= UU_W'(u_r[SINCOS_LAT-1][1]) * UU_W'(u_r[SINCOS_LAT-1][1]);
      uu_r[4] <= UU_W'(u_r[SINCOS_LAT-1][1]) * UU_W'(u_r[SINCOS_LAT-1][2]);
      uu_r[5] <= UU_W'(u_r[SINCOS_LAT-1][2]) * UU_W'(u_r[SINCOS_LAT-1][2]);
      for (int k = 0; k < 3; k++) begin
        cs_r[k] <= CS_W'(u_r[SINCOS_LAT-1][k]) * CS_W'(sin_q14);
        v1_r[k] <= v_r[SINCOS_LAT-1][k];
      end
      t_r  <= T_W'(ONE_Q14) - T_W'(cos_q14);
      c1_r <= cos_q14;
    end
  end

  // M2: outer products scaled by t
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) p_r[k] <= P_W'(uu_r[k]) * P_W'(t_r);
      cs2_r <= cs_r;
      c2_r  <= c1_r;
      v2_r  <= v1_r;
    end
  end

  // M3: matrix entries in Q.28
  always_comb begin
    logic signed [ACC_W-1:0] diag, xs [3];
    diag = ACC_W'(c2_r) <<< 28;
    for (int k = 0; k < 3; k++) xs[k] = ACC_W'(cs2_r[k]) <<< 14;
    m_nxt[0][0] = M_W'((ACC_W'(p_r[0]) + diag + ACC_W'(8192)) >>> 14);
    m_nxt[1][1] = M_W'((ACC_W'(p_r[3]) + diag + ACC_W'(8192)) >>> 14);
    m_nxt[2][2] = M_W'((ACC_W'(p_r[5]) + diag + ACC_W'(8192)) >>> 14);
    m_nxt[0][1] = M_W'((ACC_W'(p_r[1]) - xs[2] + ACC_W'(8192)) >>> 14);
    m_nxt[1][0] = M_W'((ACC_W'(p_r[1]) + xs[2] + ACC_W'(8192)) >>> 14);
    m_nxt[0][2] = M_W'((ACC_W'(p_r[2]) + xs[1] + ACC_W'(8192)) >>> 14);
    m_nxt[2][0] = M_W'((ACC_W'(p_r[2]) - xs[1] + ACC_W'(8192)) >>> 14);
    m_nxt[1][2] = M_W'((ACC_W'(p_r[4]) - xs[0] + ACC_W'(8192)) >>> 14);
    m_nxt[2][1] = M_W'((ACC_W'(p_r[4]) + xs[0] + ACC_W'(8192)) >>> 14);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r  <= m_nxt;
      v3_r <= v2_r;
    end
  end

  // M4: matrix times vector, one product per entry
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          mv_r[i][j] <= MV_W'(m_r[i][j]) * MV_W'(v3_r[j]);
    end
  end

  // M5: row sums, round to integer, saturate
  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic signed [R_W-1:0]   r;
    clip_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = SUM_W'(mv_r[i][0]) + SUM_W'(mv_r[i][1]) + SUM_W'(mv_r[i][2])
          + (SUM_W'(1) <<< 27);
      r = R_W'(acc >>> 28);
      if (r > HI_LIM) begin
        rot_nxt[i] = (VW+1)'(HI_LIM);
        clip_nxt   = 1'b1;
      end else if (r < LO_LIM) begin
        rot_nxt[i] = (VW+1)'(LO_LIM);
        clip_nxt   = 1'b1;
      end else begin
        rot_nxt[i] = (VW+1)'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_r  <= rot_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {{(OUT_TW-OUT_W){1'b0}}, rot_r[2], rot_r[1], rot_r[0]};
  assign out_tuser  = clip_r;

endmodule

>>> rtl/avvr_sincos.sv
// Pipelined rotation-mode CORDIC producing Q1.14 cosine and sine of a binary angle.
`timescale 1ns / 1ps
module avvr_sincos #(
  parameter int ANGLE_WIDTH = avvr_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [ANGLE_WIDTH-1:0]               angle,
  output logic signed [avvr_pkg::TRIG_W-1:0]   cos_q14,
  output logic signed [avvr_pkg::TRIG_W-1:0]   sin_q14
);
  import avvr_pkg::*;

  localparam int RW = CX_W + 1;

  logic signed [CX_W-1:0] x_r [0:CORDIC_ITERS];
  logic signed [CX_W-1:0] y_r [0:CORDIC_ITERS];
  logic signed [CZ_W-1:0] z_r [0:CORDIC_ITERS];
  logic [1:0]             q_r [0:CORDIC_ITERS];

  logic [PHASE_W-1:0]        phase;
  logic [PHASE_W-1:0]        phase_ofs;
  logic [1:0]                quad;
  logic [PHASE_W-1:0]        resid;
  logic signed [RW-1:0]      c_raw, s_raw, c_rnd, s_rnd;
  logic signed [TRIG_W-1:0]  c_nxt, s_nxt;
  logic signed [TRIG_W-1:0]  c_r, s_r;

  // fold the angle into a quadrant and a residual in [-1/8, 1/8) turn
  always_comb begin
    phase     = {angle, {(PHASE_W-ANGLE_WIDTH){1'b0}}};
    phase_ofs = phase + 32'h2000_0000;
    quad      = phase_ofs[PHASE_W-1 -: 2];
    resid     = phase - {quad, {(PHASE_W-2){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= CZ_W'($signed(resid));
      q_r[0] <= quad;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [CX_W-1:0] dx, dy;
    logic                   up;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    assign up = !z_r[i][CZ_W-1];
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= up ? x_r[i] - dy : x_r[i] + dy;
        y_r[i+1] <= up ? y_r[i] + dx : y_r[i] - dx;
        z_r[i+1] <= up ? z_r[i] - CZ_W'(ATAN_TABLE[i]) : z_r[i] + CZ_W'(ATAN_TABLE[i]);
        q_r[i+1] <= q_r[i];
      end
    end
  end

  // unfold the quadrant, round Q2.30 to Q1.14 and clamp to +/-1.0
  always_comb begin
    unique case (q_r[CORDIC_ITERS])
      QUAD_0: begin
        c_raw = RW'(x_r[CORDIC_ITERS]);
        s_raw = RW'(y_r[CORDIC_ITERS]);
      end
      QUAD_1: begin
        c_raw = -RW'(y_r[CORDIC_ITERS]);
        s_raw = RW'(x_r[CORDIC_ITERS]);
      end
      QUAD_2: begin
        c_raw = -RW'(x_r[CORDIC_ITERS]);
        s_raw = -RW'(y_r[CORDIC_ITERS]);
      end
      default: begin
        c_raw = RW'(y_r[CORDIC_ITERS]);
        s_raw = -RW'(x_r[CORDIC_ITERS]);
      end
    endcase
    c_rnd = (c_raw + RW'(32768)) >>> 16;
    s_rnd = (s_raw + RW'(32768)) >>> 16;
    if (c_rnd > RW'(ONE_Q14))       c_nxt = ONE_Q14;
    else if (c_rnd < -RW'(ONE_Q14)) c_nxt = -ONE_Q14;
    else                            c_nxt = TRIG_W'(c_rnd);
    if (s_rnd > RW'(ONE_Q14))       s_nxt = ONE_Q14;
    else if (s_rnd < -RW'(ONE_Q14)) s_nxt = -ONE_Q14;
    else                            s_nxt = TRIG_W'(s_rnd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
      s_r <= s_nxt;
    end
  end

  assign cos_q14 = c_r;
  assign sin_q14 = s_r;

endmodule

>>> rtl/avvr_checker.sv
// Port-level checks for the axis-angle vector rotation unit, bound to the top level.
`timescale 1ns / 1ps
module avvr_checker #(
  parameter int VEC_WIDTH   = avvr_pkg::VEC_WIDTH_DEF,
  parameter int ANGLE_WIDTH = avvr_pkg::ANGLE_WIDTH_DEF,
  localparam int IN_TW  = ((3*VEC_WIDTH + 3*avvr_pkg::AXIS_W + ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((3*(VEC_WIDTH + 1) + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_TW-1:0]  in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata,
  input logic              out_tuser
);
  localparam int VW = VEC_WIDTH;
  localparam logic [VW:0] HI = {1'b0, {VW{1'b1}}};
  localparam logic [VW:0] LO = {1'b1, {VW{1'b0}}};

  logic [VW:0] rx, ry, rz;
  assign rx = out_tdata[VW:0];
  assign ry = out_tdata[2*VW+1:VW+1];
  assign rz = out_tdata[3*VW+2:2*VW+2];

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not track output register state");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (rx == HI || rx == LO || ry == HI || ry == LO || rz == HI || rz == LO))
    else $error("clip flag set with no component at a limit");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result word changed or dropped");

  a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tready, out_tvalid}) &&
      ((in_tvalid && in_tready) -> !$isunknown(in_tdata)))
    else $error("handshake or accepted input word unknown");

endmodule

bind axis_angle_vector_rotation_unit avvr_checker #(
  .VEC_WIDTH  (VEC_WIDTH),
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_avvr_checker (.*);

>>> tb/axis_angle_vector_rotation_unit_test.sv
// Testbench for the axis-angle vector rotation unit: directed and random words, scoreboard.
`timescale 1ns / 1ps

class rotation_scoreboard;
  typedef struct packed {
    logic signed [16:0] rx;
    logic signed [16:0] ry;
    logic signed [16:0] rz;
    logic               clip;
  } rot_t;

  rot_t pending_rot[$];
  int   mismatches;
  int   checked;
  int   clip_seen;
  int   unexpected;

  function new();
    mismatches = 0;
    checked    = 0;
    clip_seen  = 0;
    unexpected = 0;
  endfunction

  static function longint shr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint clampv(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  static function void sin_cos(logic [15:0] ang, output longint c, output longint s);
    logic [31:0] atan_q32 [16];
    logic [31:0] phase;
    logic [1:0]  quad;
    logic [31:0] resid;
    longint      x, y, z, dx, dy, cr, sr;
    atan_q32 = avvr_pkg::ATAN_TABLE;
    phase = {ang, 16'h0000};
    quad  = 2'((phase + 32'h20000000) >> 30);
    resid = phase - {quad, 30'd0};
    z = longint'(signed'(resid));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q32[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atan_q32[i]);
      end
    end
    case (quad)
      avvr_pkg::QUAD_0: begin cr = x;  sr = y;  end
      avvr_pkg::QUAD_1: begin cr = -y; sr = x;  end
      avvr_pkg::QUAD_2: begin cr = -x; sr = -y; end
      default:          begin cr = y;  sr = -x; end
    endcase
    c = clampv(shr(cr + 32768, 16), -16384, 16384);
    s = clampv(shr(sr + 32768, 16), -16384, 16384);
  endfunction

  static function longint mat_term(longint ua, longint ub, longint t, longint dc, longint cr);
    return shr(ua * ub * t + dc * (64'sd1 <<< 28) + cr * (64'sd1 <<< 14) + 8192, 14);
  endfunction

  static function rot_t rotate(logic [111:0] w);
    longint v[3], u[3], m[3][3], c, s, t, acc, r;
    rot_t res;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'(signed'(w[16*i +: 16]));
      u[i] = clampv(longint'(signed'(w[48 + 16*i +: 16])), -16384, 16384);
    end
    sin_cos(w[96 +: 16], c, s);
    t = 16384 - c;
    m[0][0] = mat_term(u[0], u[0], t, c, 0);
    m[0][1] = mat_term(u[0], u[1], t, 0, -u[2] * s);
    m[0][2] = mat_term(u[0], u[2], t, 0, u[1] * s);
    m[1][0] = mat_term(u[0], u[1], t, 0, u[2] * s);
    m[1][1] = mat_term(u[1], u[1], t, c, 0);
    m[1][2] = mat_term(u[1], u[2], t, 0, -u[0] * s);
    m[2][0] = mat_term(u[0], u[2], t, 0, -u[1] * s);
    m[2][1] = mat_term(u[1], u[2], t, 0, u[0] * s);
    m[2][2] = mat_term(u[2], u[2], t, c, 0);
    res.clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
      r = shr(acc + (64'sd1 <<< 27), 28);
      if (r > 65535) begin r = 65535; res.clip = 1'b1; end
      if (r < -65536) begin r = -65536; res.clip = 1'b1; end
      if (i == 0) res.rx = 17'(r);
      else if (i == 1) res.ry = 17'(r);
      else res.rz = 17'(r);
    end
    return res;
  endfunction

  function void note_input(logic [111:0] w);
    pending_rot.push_back(rotate(w));
  endfunction

  function void check_result(logic [50:0] d, logic clip);
    rot_t exp_r;
    bit   bad;
    if (pending_rot.size() == 0) begin
      unexpected++;
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", d);
      return;
    end
    exp_r = pending_rot.pop_front();
    bad = (d[16:0] !== exp_r.rx) || (d[33:17] !== exp_r.ry) ||
          (d[50:34] !== exp_r.rz) || (clip !== exp_r.clip);
    checked++;
    if (exp_r.clip) clip_seen++;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch #%0d: exp x=%0d y=%0d z=%0d clip=%0b, got x=%0d y=%0d z=%0d clip=%0b",
                 checked, exp_r.rx, exp_r.ry, exp_r.rz, exp_r.clip,
                 $signed(d[16:0]), $signed(d[33:17]), $signed(d[50:34]), clip);
    end
  endfunction
endclass

module axis_angle_vector_rotation_unit_test;
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;
  logic         out_tuser;

  rotation_scoreboard rot_board = new();
  bit  hold_off = 1'b0;
  bit  stim_done = 1'b0;
  int  idle_cycles = 0;
  int  words_sent = 0;

  axis_angle_vector_rotation_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #2 clk = ~clk;

  // Score accepted words on both sides.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) rot_board.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) rot_board.check_result(out_tdata[50:0], out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stall pattern: runs of ready, runs of stall, some free-flowing stretches.
  initial begin
    int mode;
    @(posedge clk iff rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        @(posedge clk);
        if (hold_off) out_tready <= 1'b0;
        else if (mode == 0) out_tready <= 1'b1;
        else out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic logic [15:0] rand_axis();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom());
    if (k == 1) return 16'sd16384;
    if (k == 2) return -16'sd16384;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [111:0] rand_word();
    logic [111:0] w;
    logic [15:0] ax, ay, az;
    int k;
    w = '0;
    k = $urandom_range(0, 3);
    w[47:0] = 48'({$urandom(), $urandom()});
    if (k == 0) w[47:0] = w[47:0] & {3{16'h00ff}};
    // sometimes a unit axis along a coordinate, otherwise any random axis
    if ($urandom_range(0, 2) == 0) begin
      ax = '0; ay = '0; az = '0;
      case ($urandom_range(0, 2))
        0: ax = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        1: ay = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        default: az = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      endcase
    end else begin
      ax = rand_axis(); ay = rand_axis(); az = rand_axis();
    end
    w[95:48] = {az, ay, ax};
    w[111:96] = 16'($urandom());
    return w;
  endfunction

  task automatic send_word(logic [111:0] w);
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic pause_sender();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  initial begin
    logic [111:0] dir_words[$];
    logic [15:0]  angles[6];
    int burst;
    bit pressed;
    pressed = 1'b0;
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hFFFF};
    foreach (angles[i])
      dir_words.push_back({angles[i], 16'sd16384, 16'sd0, 16'sd0,
                           16'sh7fff, 16'sh8000, 16'sd1000});
    // zero axis, out-of-range axis, non-unit axis that saturates
    dir_words.push_back({16'h1234, 48'h0, 16'sh8000, 16'sh7fff, 16'sd12345});
    dir_words.push_back({16'h1000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                         16'sh7fff, 16'sh8000, 16'sh7fff});
    dir_words.push_back({16'h2000, 16'sd16384, 16'sd16384, 16'sd16384,
                         16'sh7fff, 16'sh7fff, 16'sh7fff});
    dir_words.push_back({16'h6000, 16'sd9459, 16'sd9459, 16'sd9459,
                         16'sh8000, 16'sh8000, 16'sh8000});
    dir_words.push_back({16'h0001, 16'sd0, 16'sd16384, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh8000});
    dir_words.push_back({16'h8000, -16'sd16384, 16'sd0, 16'sd0, 48'h0});
    dir_words.push_back({16'hA000, 16'sd0, -16'sd16384, 16'sd0, 16'sd1, -16'sd1, 16'sd1});
    dir_words.push_back({16'h7FFF, 16'sd0, 16'sd0, -16'sd16384, 16'sd300, 16'sd400, 16'sd500});
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_words[i]) send_word(dir_words[i]);
    while (words_sent < 920) begin
      if (words_sent > 300 && !pressed) begin
        // long receiver hold-off while the sender keeps offering words
        pressed  = 1'b1;
        hold_off = 1'b1;
        fork
          begin repeat (120) @(posedge clk); hold_off = 1'b0; end
        join_none
        repeat (60) send_word(rand_word());
      end
      burst = $urandom_range(1, 30);
      repeat (burst) send_word(rand_word());
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    in_tvalid <= 1'b0;
    while (rot_board.pending_rot.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d words (directed axes, angles, saturation, random); checked %0d results,",
             words_sent, rot_board.checked);
    $display("%0d of them clipped, %0d mismatches.", rot_board.clip_seen, rot_board.mismatches);
    if (rot_board.mismatches == 0 && rot_board.pending_rot.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
